@@ rtl/core/ppd_pkg.sv @@
// Shared types and constants for the point pair distance unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ppd_pkg;

   // sizing
   localparam int MAX_POINTS_DEF = 1024;
   localparam int NODE_W         = 10;
   localparam int COORD_W        = 32;
   localparam int POINT_W        = 2 * COORD_W;
   localparam int DIST_W         = 25;
   localparam int SQ_W           = 2 * COORD_W + 1;
   localparam int ROOT_STEPS     = DIST_W;
   localparam int STEP_W         = $clog2(ROOT_STEPS);
   localparam int B2_W           = 2 * ROOT_STEPS - 1;
   localparam int T_W            = 50;
   localparam int Q_W            = 54;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // metric register code with no metric of its own
   localparam logic [1:0] METRIC_RAW_UNUSED = 2'd3;

   // threshold offsets, squared sum in units of 2^-16
   localparam logic [SQ_W:0] RND_ADD  = (SQ_W + 1)'(49152);
   localparam logic [SQ_W:0] CEIL_ADD = (SQ_W + 1)'(65535);
   localparam logic [SQ_W:0] ATT_ADD  = (SQ_W + 1)'(131071);
   localparam int            RND_SHIFT = 16;
   localparam int            ATT_SHIFT = 17;

   // root iteration start values
   localparam logic [ROOT_STEPS-1:0] B_INIT  = {1'b1, {(ROOT_STEPS - 1){1'b0}}};
   localparam logic [B2_W-1:0]       B2_INIT = {1'b1, {(B2_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      METRIC_ROUND = 2'd0,
      METRIC_CEIL  = 2'd1,
      METRIC_ATT   = 2'd2
   } metric_code_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SUM,
      ST_ROOT_GO,
      ST_ROOT_WAIT
   } ppd_state_type;

   typedef enum logic [1:0] {
      RT_IDLE,
      RT_ITER,
      RT_FINISH
   } root_state_type;

   typedef struct packed {
      logic            start;
      metric_code_type mode;
   } root_ctl_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] distance;
   } root_stat_type;

endpackage

@@ rtl/core/point_pair_distance_unit.sv @@
// Top level of the point pair distance unit: command sequencer, shared
// squaring multiplier and point table. Depends on ppd_pkg, ppd_point_mem and
// ppd_root_unit.
`timescale 1ns / 1ps

// A load (req_cmd low) writes one point into the table at the accepting edge
// and keeps busy low, so loads may follow each other every cycle. A query
// (req_cmd high) holds busy high through two table reads, the coordinate
// differences, two squarings on the one 32x32 multiplier, the sum, a
// threshold step, 25 root iterations that settle one result bit per cycle,
// and a rounding step; rsp_valid is high for one cycle, in the last cycle
// that busy is high, and start is taken again in the next. The receiver
// cannot stall: a result stays on rsp_distance until the next query finishes.
// Queries must name points that were loaded before. The user is to raise
// csr_wr_en only while busy is low; the block itself does not enforce it.
module point_pair_distance_unit
   import ppd_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_cmd,
   input  logic [NODE_W-1:0]         req_point_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic [NODE_W-1:0]         req_node_a,
   input  logic [NODE_W-1:0]         req_node_b,
   output logic                      rsp_valid,
   output logic [DIST_W-1:0]         rsp_distance,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_POINTS);

   ppd_state_type   state_ff, state_in;
   metric_code_type metric_ff, metric_in;

   logic [ADDR_W-1:0]  na_ff, nb_ff;
   logic               na_ok_ff, nb_ok_ff;
   logic [POINT_W-1:0] pa_ff;
   logic [COORD_W-1:0] dx_ff, dy_ff;
   logic [POINT_W-1:0] prod_ff;
   logic [SQ_W-1:0]    s_ff;

   logic               accept;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [POINT_W-1:0] rd_data;
   logic [POINT_W-1:0] pb;
   logic [COORD_W:0]   diff_x, diff_y, neg_x, neg_y;
   logic [COORD_W-1:0] mul_a;
   logic [POINT_W-1:0] product;
   root_ctl_type       root_ctl;
   root_stat_type      root_stat;

   assign accept = start && !busy;
   assign wr_en  = accept && (req_cmd == CMD_LOAD) && (32'(req_point_index) < MAX_POINTS);

   // metric register, unused code falls back to rounded euclidean
   assign metric_in = (csr_wr_data == METRIC_RAW_UNUSED) ? METRIC_ROUND
                                                          : metric_code_type'(csr_wr_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_ROUND;
      end else if (csr_wr_en) begin
         metric_ff <= metric_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (accept && (req_cmd == CMD_QUERY)) state_in = ST_RD_A;
         ST_RD_A:      state_in = ST_RD_B;
         ST_RD_B:      state_in = ST_DIFF;
         ST_DIFF:      state_in = ST_SQ_X;
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_SUM;
         ST_SUM:       state_in = ST_ROOT_GO;
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (root_stat.done) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy           = 1'b1;
      rd_addr        = nb_ff;
      root_ctl.start = 1'b0;
      root_ctl.mode  = metric_ff;
      unique case (state_ff)
         ST_IDLE:      busy = 1'b0;
         ST_RD_A:      rd_addr = na_ff;
         ST_RD_B:      rd_addr = nb_ff;
         ST_ROOT_GO:   root_ctl.start = 1'b1;
         ST_DIFF, ST_SQ_X, ST_SQ_Y, ST_SUM, ST_ROOT_WAIT: busy = 1'b1;
         default:      busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // point table
   ppd_point_mem #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_point_index)),
      .wr_data ({req_coord_y, req_coord_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries beyond the table read as the origin
   assign pb = nb_ok_ff ? rd_data : '0;

   // absolute coordinate differences
   assign diff_x = {pa_ff[COORD_W-1], pa_ff[COORD_W-1:0]}
                 - {pb[COORD_W-1], pb[COORD_W-1:0]};
   assign diff_y = {pa_ff[POINT_W-1], pa_ff[POINT_W-1:COORD_W]}
                 - {pb[POINT_W-1], pb[POINT_W-1:COORD_W]};
   assign neg_x  = -diff_x;
   assign neg_y  = -diff_y;

   // shared squaring multiplier
   assign mul_a   = (state_ff == ST_SQ_X) ? dx_ff : dy_ff;
   assign product = mul_a * mul_a;

   // query datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         na_ff    <= ADDR_W'(req_node_a);
         nb_ff    <= ADDR_W'(req_node_b);
         na_ok_ff <= 32'(req_node_a) < MAX_POINTS;
         nb_ok_ff <= 32'(req_node_b) < MAX_POINTS;
      end
      if (state_ff == ST_RD_B) begin
         pa_ff <= na_ok_ff ? rd_data : '0;
      end
      if (state_ff == ST_DIFF) begin
         dx_ff <= diff_x[COORD_W] ? neg_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
         dy_ff <= diff_y[COORD_W] ? neg_y[COORD_W-1:0] : diff_y[COORD_W-1:0];
      end
      if ((state_ff == ST_SQ_X) || (state_ff == ST_SQ_Y)) begin
         prod_ff <= product;
      end
      if (state_ff == ST_SQ_Y) begin
         s_ff <= SQ_W'(prod_ff);
      end else if (state_ff == ST_SUM) begin
         s_ff <= s_ff + SQ_W'(prod_ff);
      end
   end

   // root search and rounding
   ppd_root_unit u_root (
      .clock  (clock),
      .reset  (reset),
      .ctl    (root_ctl),
      .sq_sum (s_ff),
      .stat   (root_stat)
   );

   assign rsp_valid    = root_stat.done;
   assign rsp_distance = root_stat.distance;

endmodule

@@ rtl/core/ppd_point_mem.sv @@
// Point table: one write port, one read port with registered read data.
// Depends on ppd_pkg for the entry width.
`timescale 1ns / 1ps

module ppd_point_mem
   import ppd_pkg::*;
#(
   parameter int DEPTH  = MAX_POINTS_DEF,
   parameter int ADDR_W = $clog2(MAX_POINTS_DEF)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [POINT_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [POINT_W-1:0] rd_data
);

   logic [POINT_W-1:0] mem [DEPTH];
   logic [POINT_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ppd_root_unit.sv @@
// Bit-serial square root, rounded, ceiling or att-scaled, one result bit per
// cycle, compared against a threshold taken from the squared distance. Depends on ppd_pkg.
`timescale 1ns / 1ps

module ppd_root_unit
   import ppd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  root_ctl_type    ctl,
   input  logic [SQ_W-1:0] sq_sum,
   output root_stat_type   stat
);

   // metric weight on the square: 5 for att, 1 otherwise
   function automatic logic [Q_W-1:0] mode_scale(metric_code_type mode, logic [Q_W-1:0] v);
      logic [Q_W-1:0] r;
      unique case (mode)
         METRIC_ATT:   r = (v << 2) + v;
         METRIC_ROUND: r = v;
         METRIC_CEIL:  r = v;
         default:      r = v;
      endcase
      return r;
   endfunction

   // constant part of the square growth for the trial bit
   function automatic logic [Q_W-1:0] const_term(metric_code_type mode,
                                                  logic [B2_W-1:0] b2v,
                                                  logic [ROOT_STEPS-1:0] bv);
      logic [Q_W-1:0] r;
      r = mode_scale(mode, Q_W'(b2v));
      if (mode == METRIC_ROUND) begin
         r = r - Q_W'(bv);
      end
      return r;
   endfunction

   root_state_type        state_ff, state_in;
   metric_code_type       mode_ff, mode_in;
   logic [T_W-1:0]        t_ff, t_in;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [Q_W-1:0]        p_ff, p_in;
   logic [Q_W-1:0]        kc_ff, kc_in;
   logic [ROOT_STEPS-1:0] b_ff, b_in;
   logic [B2_W-1:0]       b2_ff, b2_in;
   logic [DIST_W-1:0]     n_ff, n_in;
   logic                  zero_ff, zero_in;
   logic [STEP_W-1:0]     count_ff, count_in;
   logic                  done_ff, done_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;

   logic           do_load, do_step, do_finish;
   logic [SQ_W:0]  thr_sum;
   logic [Q_W-1:0] cand;
   logic           take;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RT_IDLE:   if (ctl.start) state_in = RT_ITER;
         RT_ITER:   if (count_ff == '0) state_in = RT_FINISH;
         RT_FINISH: state_in = RT_IDLE;
         default:   state_in = RT_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      do_load   = 1'b0;
      do_step   = 1'b0;
      do_finish = 1'b0;
      unique case (state_ff)
         RT_IDLE:   do_load   = ctl.start;
         RT_ITER:   do_step   = 1'b1;
         RT_FINISH: do_finish = 1'b1;
         default:   do_load   = 1'b0;
      endcase
   end

   // threshold: integer bound on the scaled square of the candidate
   always_comb begin
      unique case (ctl.mode)
         METRIC_ROUND: thr_sum = {1'b0, sq_sum} + RND_ADD;
         METRIC_CEIL:  thr_sum = {1'b0, sq_sum} + CEIL_ADD;
         METRIC_ATT:   thr_sum = {1'b0, sq_sum} + ATT_ADD;
         default:      thr_sum = {1'b0, sq_sum} + RND_ADD;
      endcase
   end

   // trial square of n with the current bit set, kept incrementally
   assign cand = q_ff + p_ff + kc_ff;
   assign take = cand < Q_W'(t_ff);

   // datapath next values
   always_comb begin
      mode_in  = mode_ff;
      t_in     = t_ff;
      q_in     = q_ff;
      p_in     = p_ff;
      kc_in    = kc_ff;
      b_in     = b_ff;
      b2_in    = b2_ff;
      n_in     = n_ff;
      zero_in  = zero_ff;
      count_in = count_ff;
      dist_in  = dist_ff;
      if (do_load) begin
         mode_in  = ctl.mode;
         t_in     = (ctl.mode == METRIC_ATT) ? T_W'(thr_sum >> ATT_SHIFT)
                                             : T_W'(thr_sum >> RND_SHIFT);
         zero_in  = (sq_sum == '0);
         q_in     = '0;
         p_in     = '0;
         kc_in    = const_term(ctl.mode, B2_INIT, B_INIT);
         b_in     = B_INIT;
         b2_in    = B2_INIT;
         n_in     = '0;
         count_in = STEP_W'(ROOT_STEPS - 1);
      end else if (do_step) begin
         if (take) begin
            q_in = cand;
            n_in = n_ff | b_ff;
            p_in = (p_ff >> 1) + mode_scale(mode_ff, Q_W'(b2_ff));
         end else begin
            p_in = p_ff >> 1;
         end
         b_in     = b_ff >> 1;
         b2_in    = b2_ff >> 2;
         kc_in    = const_term(mode_ff, b2_ff >> 2, b_ff >> 1);
         count_in = count_ff - STEP_W'(1);
      end else if (do_finish) begin
         if (mode_ff == METRIC_ROUND) begin
            dist_in = n_ff;
         end else if (zero_ff) begin
            dist_in = '0;
         end else if (&n_ff) begin
            dist_in = n_ff;
         end else begin
            dist_in = n_ff + DIST_W'(1);
         end
      end
   end

   assign done_in = do_finish;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      t_ff    <= t_in;
      q_ff    <= q_in;
      p_ff    <= p_in;
      kc_ff   <= kc_in;
      b_ff    <= b_in;
      b2_ff   <= b2_in;
      n_ff    <= n_in;
      zero_ff <= zero_in;
      dist_ff <= dist_in;
   end

   assign stat.done     = done_ff;
   assign stat.distance = dist_ff;

endmodule

@@ tb/sv/point_pair_distance_unit_tb.sv @@
// Self-checking testbench for point_pair_distance_unit: directed rows, then
// random loads and queries under every metric code with varied sender idling.
// Depends on ppd_pkg and the point_pair_distance_unit RTL.
`timescale 1ns / 1ps

module point_pair_distance_unit_tb;
   import ppd_pkg::*;

   localparam int                CLK_HALF      = 6;
   localparam int                PHASES        = 8;
   localparam int                PHASE_ITEMS   = 130;
   localparam int                DIR_ROWS      = 22;
   localparam int                SETTLE_CYCLES = 40;
   localparam logic [DIST_W-1:0] DIST_CAP      = {DIST_W{1'b1}};
   // att bound: n^2 * 10 in units of 2^-16
   localparam logic [127:0]      ATT_BOUND_SCALE = 128'd655360;

   typedef struct packed {
      logic               cmd;
      logic [NODE_W-1:0]  idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [NODE_W-1:0]  a;
      logic [NODE_W-1:0]  b;
   } point_cmd_type;

   typedef struct packed {
      point_cmd_type     item;
      logic              known;
      logic [DIST_W-1:0] want_distance;
   } dir_row_type;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      start           = 1'b0;
   logic                      busy;
   logic                      req_cmd         = CMD_LOAD;
   logic [NODE_W-1:0]         req_point_index = '0;
   logic signed [COORD_W-1:0] req_coord_x     = '0;
   logic signed [COORD_W-1:0] req_coord_y     = '0;
   logic [NODE_W-1:0]         req_node_a      = '0;
   logic [NODE_W-1:0]         req_node_b      = '0;
   logic                      rsp_valid;
   logic [DIST_W-1:0]         rsp_distance;
   logic                      csr_wr_en       = 1'b0;
   logic [1:0]                csr_wr_data     = '0;

   // predictor state
   logic [POINT_W-1:0] point_table [MAX_POINTS_DEF];
   bit                 point_loaded [MAX_POINTS_DEF];
   int                 loaded_nodes [$];
   logic [1:0]         metric_sel = METRIC_ROUND;
   logic [DIST_W-1:0]  dist_expect_q [$];
   logic [DIST_W-1:0]  dist_front;

   int err_count   = 0;
   int load_count  = 0;
   int query_count = 0;
   int check_count = 0;
   int idle_pct    = 0;

   point_pair_distance_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_point_index (req_point_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .rsp_valid       (rsp_valid),
      .rsp_distance    (rsp_distance),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // clock
   always #(CLK_HALF) clock = ~clock;

   // run limit
   initial begin
      #(10_000_000);
      $display("timeout at %0t, %0d distances still pending", $time, dist_expect_q.size());
      $display("point_pair_distance_unit_tb: done, errors");
      $finish;
   end

   task automatic mismatch_note(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      err_count++;
   endtask

   // squared gap of one signed coordinate pair, units of 2^-16
   function automatic logic [127:0] coord_gap_sq(input logic [COORD_W-1:0] p,
                                                 input logic [COORD_W-1:0] q);
      logic signed [COORD_W:0] d;
      logic [127:0]            mag;
      d = $signed({p[COORD_W-1], p}) - $signed({q[COORD_W-1], q});
      mag = '0;
      mag[COORD_W:0] = d[COORD_W] ? -d : d;
      return mag * mag;
   endfunction

   // exact integer distance by bitwise search over the candidate root
   function automatic logic [DIST_W-1:0] predict_distance(input logic [POINT_W-1:0] pa,
                                                          input logic [POINT_W-1:0] pb,
                                                          input logic [1:0] metric);
      logic [127:0]      sq_sum;
      logic [127:0]      span;
      logic [127:0]      bound;
      logic [DIST_W-1:0] n;
      logic [DIST_W-1:0] cand;
      logic [1:0]        m;
      int                k;
      sq_sum = coord_gap_sq(pa[COORD_W-1:0], pb[COORD_W-1:0])
             + coord_gap_sq(pa[POINT_W-1:COORD_W], pb[POINT_W-1:COORD_W]);
      m = metric;
      if (m == METRIC_RAW_UNUSED) m = METRIC_ROUND;
      n = '0;
      // rounded: largest n with (n - 1/2)^2 <= d^2
      if (m == METRIC_ROUND) begin
         for (k = DIST_W - 1; k >= 0; k--) begin
            cand = n | (25'd1 << k);
            span = ({103'd0, cand} << 8) - 128'd128;
            if (span * span <= sq_sum) n = cand;
         end
         return n;
      end
      if (sq_sum == 0) return '0;
      // ceiling and att: largest n whose bound stays below, answer n + 1
      for (k = DIST_W - 1; k >= 0; k--) begin
         cand = n | (25'd1 << k);
         span = {103'd0, cand};
         if (m == METRIC_ATT) bound = span * span * ATT_BOUND_SCALE;
         else bound = (span << 8) * (span << 8);
         if (sq_sum > bound) n = cand;
      end
      return (n >= DIST_CAP) ? DIST_CAP : n + 25'd1;
   endfunction

   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(9))
         0: return $urandom();
         1: begin
            case ($urandom_range(4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               3: return 32'h8000_0001;
               default: return '0;
            endcase
         end
         // whole units give exact distances, half units hit rounding ties
         2, 3: return 32'((int'($urandom_range(2000)) - 1000) * 256);
         4: return 32'((int'($urandom_range(2000)) - 1000) * 128);
         default: return 32'(int'($urandom_range(2097152)) - 1048576);
      endcase
   endfunction

   // random load or query; queries only name loaded entries
   function automatic point_cmd_type random_cmd();
      point_cmd_type it;
      it.idx = NODE_W'($urandom_range(MAX_POINTS_DEF - 1));
      it.x   = random_coord();
      it.y   = random_coord();
      it.a   = NODE_W'($urandom());
      it.b   = NODE_W'($urandom());
      if (loaded_nodes.size() < 2 || $urandom_range(99) < 35) begin
         it.cmd = CMD_LOAD;
      end else begin
         it.cmd = CMD_QUERY;
         it.a = NODE_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
         it.b = NODE_W'(loaded_nodes[$urandom_range(loaded_nodes.size() - 1)]);
         if ($urandom_range(9) == 0) it.b = it.a;
      end
      return it;
   endfunction

   // drive one item from a falling edge and hold it until the transfer
   task automatic send_item(input point_cmd_type item, input logic known,
                            input logic [DIST_W-1:0] known_dist);
      start           = 1'b1;
      req_cmd         = item.cmd;
      req_point_index = item.idx;
      req_coord_x     = item.x;
      req_coord_y     = item.y;
      req_node_a      = item.a;
      req_node_b      = item.b;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (item.cmd == CMD_LOAD) begin
         point_table[item.idx] = {item.y, item.x};
         if (!point_loaded[item.idx]) loaded_nodes.push_back(int'(item.idx));
         point_loaded[item.idx] = 1'b1;
         load_count++;
      end else begin
         if (known) dist_expect_q.push_back(known_dist);
         else dist_expect_q.push_back(predict_distance(point_table[item.a],
                                                       point_table[item.b], metric_sel));
         query_count++;
      end
      @(negedge clock);
   endtask

   // metric write once all pending distances are back
   task automatic set_metric(input logic [1:0] code);
      start = 1'b0;
      while (dist_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = code;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      metric_sel = code;
   endtask

   // result check at every rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (dist_expect_q.size() == 0) begin
            mismatch_note($sformatf("distance %0d with no query pending", rsp_distance));
         end else begin
            dist_front = dist_expect_q.pop_front();
            check_count++;
            if (rsp_distance !== dist_front)
               mismatch_note($sformatf("distance %0d, predicted %0d (metric %0d)",
                                       rsp_distance, dist_front, metric_sel));
         end
      end
   end

   // stimulus
   initial begin : stimulus
      dir_row_type directed_rows [DIR_ROWS];
      logic [1:0]  phase_metric [PHASES];
      int          phase_idle [PHASES];
      int          r;
      int          p;
      int          i;

      directed_rows = '{
         '{'{CMD_LOAD,  10'd0,    32'h0000_0000, 32'h0000_0000, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_LOAD,  10'd1,    32'h0000_0300, 32'h0000_0400, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd0,    10'd1},    1'b1, 25'd5},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd1,    10'd1},    1'b1, 25'd0},
         '{'{CMD_LOAD,  10'd1023, 32'h7fff_ffff, 32'h7fff_ffff, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_LOAD,  10'd2,    32'h8000_0000, 32'h8000_0000, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd1023, 10'd2},    1'b0, 25'd0},
         '{'{CMD_LOAD,  10'd3,    32'h8000_0000, 32'h7fff_ffff, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd3,    10'd1023},
           1'b1, 25'd16777216},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd2,    10'd3},
           1'b1, 25'd16777216},
         '{'{CMD_LOAD,  10'd4,    32'h0000_0080, 32'h0000_0000, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd0,    10'd4},    1'b1, 25'd1},
         '{'{CMD_LOAD,  10'd5,    32'h0000_0000, 32'hffff_ff81, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd5,    10'd0},    1'b1, 25'd0},
         '{'{CMD_LOAD,  10'd6,    32'hffff_fd00, 32'hffff_fc00, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd6,    10'd1},    1'b1, 25'd10},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd1023, 10'd1023}, 1'b1, 25'd0},
         '{'{CMD_LOAD,  10'd512,  32'h1234_5678, 32'hedcb_a987, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd512,  10'd4},    1'b0, 25'd0},
         '{'{CMD_LOAD,  10'd341,  32'h5555_5555, 32'haaaa_aaaa, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_LOAD,  10'd682,  32'haaaa_aaaa, 32'h5555_5555, 10'd0,    10'd0},    1'b0, 25'd0},
         '{'{CMD_QUERY, 10'd0,    32'h0000_0000, 32'h0000_0000, 10'd341,  10'd682},  1'b0, 25'd0}
      };
      phase_metric = '{METRIC_CEIL, METRIC_ATT, METRIC_RAW_UNUSED, METRIC_ROUND,
                       METRIC_ATT, METRIC_CEIL, METRIC_ROUND, METRIC_ATT};
      phase_idle   = '{0, 69, 37, 0, 69, 37, 69, 0};

      // synchronous reset, then release on a falling edge
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows under the reset metric
      for (r = 0; r < DIR_ROWS; r++)
         send_item(directed_rows[r].item, directed_rows[r].known,
                   directed_rows[r].want_distance);

      // random phases, one metric and one idle rate each
      for (p = 0; p < PHASES; p++) begin
         set_metric(phase_metric[p]);
         idle_pct = phase_idle[p];
         for (i = 0; i < PHASE_ITEMS; i++) begin
            while ($urandom_range(99) < idle_pct) begin
               start = 1'b0;
               @(negedge clock);
            end
            send_item(random_cmd(), 1'b0, '0);
         end
      end

      // drain
      start = 1'b0;
      while (dist_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d loads and %0d queries, %0d distances compared",
               load_count, query_count, check_count);
      $display("metrics rounded, ceiling, att and the spare code, sender idle 0/37/69 pct");
      if (err_count == 0) begin
         $display("point_pair_distance_unit_tb: done, clean");
      end else begin
         $display("mismatches: %0d", err_count);
         $display("point_pair_distance_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
